// File: rtl/stpr_pkg.sv
// Package with shared constants and command/status types of the stepper ramp generator.
`default_nettype none

package stpr_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int FRAC_BITS      = 16;
   localparam int SPEED_INT_BITS = 14;
   localparam int ACC_BITS       = 16;
   localparam int WAIT_W         = 13;
   localparam int SPEED_W        = SPEED_INT_BITS + FRAC_BITS;
   localparam int DVD_W          = ACC_BITS + 2 * FRAC_BITS;
   localparam int SUM_W          = DVD_W + 1;
   localparam int DIV_CNT_W      = $clog2(DVD_W + 1);

   localparam logic [DVD_W-1:0]  US_DVD   = DVD_W'(64'(1000000) << FRAC_BITS);
   localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

   localparam logic       OP_START   = 1'b0;
   localparam logic       OP_STEP    = 1'b1;
   localparam logic [1:0] AXIS_PULLEY = 2'd0;
   localparam logic [1:0] AXIS_IDLER  = 2'd2;
   localparam logic [1:0] ST_RUN     = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_STALL   = 2'd2;
   localparam logic       CSR_STEALTH   = 1'b0;
   localparam logic       CSR_MIN_SPEED = 1'b1;
   localparam logic       SEL_WAIT  = 1'b0;
   localparam logic       SEL_DELTA = 1'b1;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_sel;
      logic latch_w;
      logic commit;
   } stpr_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } stpr_stat_type;

endpackage

`default_nettype wire

// File: rtl/stpr_div.sv
// Restoring divider that produces one quotient bit per clock cycle.
`default_nettype none

module stpr_div
   import stpr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DVD_W-1:0]   dividend,
   input  wire logic [SPEED_W-1:0] divisor,
   output logic                    done,
   output logic [DVD_W-1:0]        quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [SPEED_W-1:0]   rem_ff, rem_in;
   logic [SPEED_W-1:0]   dvs_ff, dvs_in;
   logic [SPEED_W:0]     rem_sh;
   logic [SPEED_W:0]     diff;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// File: rtl/stpr_datapath.sv
// Datapath holding the move state, speed ramp arithmetic and the result registers.
`default_nettype none

module stpr_datapath
   import stpr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire stpr_cmd_type              cmd,
   output stpr_stat_type                  stat,
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_index,
   input  wire logic [SPEED_INT_BITS-1:0] csr_wdata,
   input  wire logic                      req_op,
   input  wire logic [1:0]                req_axis,
   input  wire logic signed [15:0]        req_move_steps,
   input  wire logic [SPEED_INT_BITS-1:0] req_top_speed,
   input  wire logic [ACC_BITS-1:0]       req_accel,
   input  wire logic                      req_stall_enable,
   input  wire logic                      req_sensor_stop_enable,
   input  wire logic                      req_stall_seen,
   input  wire logic                      req_filament_seen,
   output logic                           rsp_pulse,
   output logic                           rsp_dir_level,
   output logic [WAIT_W-1:0]              rsp_wait_us,
   output logic [1:0]                     rsp_status
);

   typedef enum logic [1:0] {PH_ACCEL, PH_CRUISE, PH_DECEL} phase_type;

   logic                      stealth_ff;
   logic [SPEED_INT_BITS-1:0] min_ff;

   logic                      op_ff, stall_en_ff, sensor_en_ff, stall_seen_ff, fil_seen_ff;
   logic [1:0]                axis_ff;
   logic [15:0]               steps_ff;
   logic [SPEED_INT_BITS-1:0] top_in_ff;
   logic [ACC_BITS-1:0]       acc_in_ff;

   logic [SPEED_W-1:0]        speed_ff, speed_in;
   logic [COUNT_BITS-1:0]     left_ff, left_in, done_ff, done_in, ramp_ff, ramp_in;
   phase_type                 phase_ff, phase_in;
   logic                      active_ff, active_in, m_pulley_ff, m_pulley_in;
   logic                      fwd_ff, fwd_in, stall_on_ff, stall_on_in;
   logic                      sensor_on_ff, sensor_on_in, dir_ff, dir_in;
   logic [SPEED_INT_BITS-1:0] top_ff, top_in;
   logic [ACC_BITS-1:0]       acc_ff, acc_in;
   logic [WAIT_W-1:0]         w_ff;

   logic                      pulse_ff, pulse_in;
   logic [WAIT_W-1:0]         wait_ff, wait_in;
   logic [1:0]                status_ff, status_in;

   logic [DVD_W-1:0]          quot;
   logic [DVD_W-1:0]          dividend;
   logic                      div_done;
   logic                      stall_end, fil_end;
   logic                      neg;
   logic [16:0]               mag;
   logic [SPEED_INT_BITS-1:0] min_eff;
   logic [SPEED_W-1:0]        lo_q, v_dec;
   logic [SUM_W-1:0]          v_sum, top_q;
   logic [COUNT_BITS-1:0]     sd, sl;

   assign dividend = (cmd.div_sel == SEL_DELTA) ? {acc_ff, {(2*FRAC_BITS){1'b0}}} : US_DVD;

   stpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (speed_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      stall_end = stall_on_ff & stall_seen_ff;
      fil_end   = m_pulley_ff & sensor_on_ff & (fwd_ff ? fil_seen_ff : ~fil_seen_ff);
      stat.need_div = (op_ff == OP_STEP) & active_ff & ~stall_end & ~fil_end;
      stat.div_done = div_done;

      neg     = steps_ff[15];
      mag     = neg ? (17'h10000 - {1'b0, steps_ff}) : {1'b0, steps_ff};
      min_eff = (min_ff == '0) ? SPEED_INT_BITS'(1) : min_ff;
      lo_q    = {min_eff, {FRAC_BITS{1'b0}}};
      sd      = done_ff + 1'b1;
      sl      = left_ff - 1'b1;
      v_sum   = SUM_W'(speed_ff) + SUM_W'(quot);
      top_q   = SUM_W'({top_ff, {FRAC_BITS{1'b0}}});
      v_dec   = (quot >= DVD_W'(speed_ff)) ? lo_q : speed_ff - quot[SPEED_W-1:0];
      if (v_dec < lo_q) begin
         v_dec = lo_q;
      end

      speed_in     = speed_ff;
      left_in      = left_ff;
      done_in      = done_ff;
      ramp_in      = ramp_ff;
      phase_in     = phase_ff;
      active_in    = active_ff;
      m_pulley_in  = m_pulley_ff;
      fwd_in       = fwd_ff;
      stall_on_in  = stall_on_ff;
      sensor_on_in = sensor_on_ff;
      dir_in       = dir_ff;
      top_in       = top_ff;
      acc_in       = acc_ff;
      pulse_in     = 1'b0;
      wait_in      = '0;
      status_in    = ST_DONE;

      if (op_ff == OP_START) begin
         speed_in     = lo_q;
         done_in      = '0;
         ramp_in      = '0;
         phase_in     = PH_ACCEL;
         left_in      = '0;
         active_in    = 1'b0;
         m_pulley_in  = 1'b0;
         fwd_in       = 1'b0;
         stall_on_in  = 1'b0;
         sensor_on_in = 1'b0;
         dir_in       = 1'b0;
         top_in       = '0;
         acc_in       = '0;
         if (axis_ff <= AXIS_IDLER) begin
            m_pulley_in  = axis_ff == AXIS_PULLEY;
            fwd_in       = ~neg & (steps_ff != '0);
            dir_in       = (axis_ff == AXIS_PULLEY) ? neg : ~neg;
            stall_on_in  = stall_en_ff & ~stealth_ff;
            sensor_on_in = sensor_en_ff;
            top_in       = (top_in_ff == '0) ? SPEED_INT_BITS'(1) : top_in_ff;
            acc_in       = acc_in_ff;
            left_in      = COUNT_BITS'(mag);
            active_in    = COUNT_BITS'(mag) != '0;
         end
         status_in = active_in ? ST_RUN : ST_DONE;
      end else if (active_ff) begin
         pulse_in = 1'b1;
         if (stall_end) begin
            active_in = 1'b0;
            status_in = ST_STALL;
         end else if (fil_end) begin
            active_in = 1'b0;
            status_in = ST_DONE;
         end else begin
            done_in = sd;
            left_in = sl;
            case (phase_ff)
               PH_ACCEL: begin
                  if (v_sum >= top_q) begin
                     ramp_in  = sd;
                     phase_in = PH_CRUISE;
                     speed_in = top_q[SPEED_W-1:0];
                  end else begin
                     speed_in = v_sum[SPEED_W-1:0];
                     if (sd > sl) begin
                        ramp_in  = sd;
                        phase_in = PH_DECEL;
                     end
                  end
               end
               PH_CRUISE: begin
                  if (sl <= ramp_ff) begin
                     phase_in = PH_DECEL;
                  end
               end
               default: begin
                  speed_in = v_dec;
               end
            endcase
            if (sl == '0) begin
               active_in = 1'b0;
               status_in = ST_DONE;
            end else begin
               status_in = ST_RUN;
               wait_in   = w_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stealth_ff   <= 1'b0;
         min_ff       <= SPEED_INT_BITS'(200);
         speed_ff     <= '0;
         left_ff      <= '0;
         done_ff      <= '0;
         ramp_ff      <= '0;
         phase_ff     <= PH_ACCEL;
         active_ff    <= 1'b0;
         m_pulley_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         stall_on_ff  <= 1'b0;
         sensor_on_ff <= 1'b0;
         dir_ff       <= 1'b0;
         top_ff       <= '0;
         acc_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_STEALTH) begin
               stealth_ff <= csr_wdata[0];
            end else begin
               min_ff <= csr_wdata;
            end
         end
         if (cmd.commit) begin
            speed_ff     <= speed_in;
            left_ff      <= left_in;
            done_ff      <= done_in;
            ramp_ff      <= ramp_in;
            phase_ff     <= phase_in;
            active_ff    <= active_in;
            m_pulley_ff  <= m_pulley_in;
            fwd_ff       <= fwd_in;
            stall_on_ff  <= stall_on_in;
            sensor_on_ff <= sensor_on_in;
            dir_ff       <= dir_in;
            top_ff       <= top_in;
            acc_ff       <= acc_in;
         end
      end
      if (cmd.capture) begin
         op_ff         <= req_op;
         axis_ff       <= req_axis;
         steps_ff      <= req_move_steps;
         top_in_ff     <= req_top_speed;
         acc_in_ff     <= req_accel;
         stall_en_ff   <= req_stall_enable;
         sensor_en_ff  <= req_sensor_stop_enable;
         stall_seen_ff <= req_stall_seen;
         fil_seen_ff   <= req_filament_seen;
      end
      if (cmd.latch_w) begin
         w_ff <= (quot > DVD_W'(WAIT_MAX)) ? WAIT_MAX : quot[WAIT_W-1:0];
      end
      if (cmd.commit) begin
         pulse_ff  <= pulse_in;
         wait_ff   <= wait_in;
         status_ff <= status_in;
      end
   end

   assign rsp_pulse     = pulse_ff;
   assign rsp_dir_level = dir_ff;
   assign rsp_wait_us   = wait_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

// File: rtl/stpr_ctrl.sv
// Controller state machine that sequences capture, the two divisions of a running step and the result transfer.
`default_nettype none

module stpr_ctrl
   import stpr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire stpr_stat_type stat,
   output stpr_cmd_type       cmd
);

   typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV_W, S_DIV_D, S_COMMIT} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.need_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_WAIT;
               state_in      = S_DIV_W;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIV_W: begin
            if (stat.div_done) begin
               cmd.latch_w   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_DELTA;
               state_in      = S_DIV_D;
            end
         end
         S_DIV_D: begin
            cmd.div_sel = SEL_DELTA;
            if (stat.div_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.div_sel = SEL_DELTA;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/stepper_trapezoid_ramp.sv
// Top level of the trapezoidal step-rate generator for one stepper axis.
// A start transfer latches a move; each step of a running move issues one pulse,
// checks the stall and filament sensors and returns the microsecond delay to the
// next step while the speed ramps up to top speed, cruises and ramps down to the
// minimum speed. Start transfers, steps on an idle move and steps stopped by a
// sensor skip the divider; any other step uses the bit-serial divider to compute
// the delay and then the speed change one after the other.
// One item is processed at a time; a finished result waits in the output register.
`default_nettype none

module stepper_trapezoid_ramp
   import stpr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_index,
   input  wire logic [SPEED_INT_BITS-1:0] csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_op,
   input  wire logic [1:0]                req_axis,
   input  wire logic signed [15:0]        req_move_steps,
   input  wire logic [SPEED_INT_BITS-1:0] req_top_speed,
   input  wire logic [ACC_BITS-1:0]       req_accel,
   input  wire logic                      req_stall_enable,
   input  wire logic                      req_sensor_stop_enable,
   input  wire logic                      req_stall_seen,
   input  wire logic                      req_filament_seen,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_pulse,
   output logic                           rsp_dir_level,
   output logic [WAIT_W-1:0]              rsp_wait_us,
   output logic [1:0]                     rsp_status
);

   stpr_cmd_type  cmd;
   stpr_stat_type stat;

   stpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stpr_datapath u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_op                 (req_op),
      .req_axis               (req_axis),
      .req_move_steps         (req_move_steps),
      .req_top_speed          (req_top_speed),
      .req_accel              (req_accel),
      .req_stall_enable       (req_stall_enable),
      .req_sensor_stop_enable (req_sensor_stop_enable),
      .req_stall_seen         (req_stall_seen),
      .req_filament_seen      (req_filament_seen),
      .rsp_pulse              (rsp_pulse),
      .rsp_dir_level          (rsp_dir_level),
      .rsp_wait_us            (rsp_wait_us),
      .rsp_status             (rsp_status)
   );

endmodule

`default_nettype wire

// File: tb/stepper_trapezoid_ramp_tb.sv
// Self-checking testbench for the trapezoidal stepper ramp generator.
`timescale 1ns / 1ps

module stepper_trapezoid_ramp_tb;
   import stpr_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 250;

   typedef enum logic [1:0] {RAMP_UP, RAMP_CRUISE, RAMP_DOWN} ramp_phase_type;

   typedef struct {
      logic                      op;
      logic [1:0]                axis;
      logic signed [15:0]        steps;
      logic [SPEED_INT_BITS-1:0] top;
      logic [ACC_BITS-1:0]       acc;
      logic                      stall_en;
      logic                      sensor_en;
      logic                      stall_seen;
      logic                      fil_seen;
   } step_cmd_type;

   typedef struct {
      logic              pulse;
      logic              dir;
      logic [WAIT_W-1:0] wait_us;
      logic [1:0]        status;
   } step_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic                      csr_index = 1'b0;
   logic [SPEED_INT_BITS-1:0] csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_op = 1'b0;
   logic [1:0]                req_axis = '0;
   logic signed [15:0]        req_move_steps = '0;
   logic [SPEED_INT_BITS-1:0] req_top_speed = '0;
   logic [ACC_BITS-1:0]       req_accel = '0;
   logic                      req_stall_enable = 1'b0;
   logic                      req_sensor_stop_enable = 1'b0;
   logic                      req_stall_seen = 1'b0;
   logic                      req_filament_seen = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_pulse;
   logic                      rsp_dir_level;
   logic [WAIT_W-1:0]         rsp_wait_us;
   logic [1:0]                rsp_status;

   step_cmd_type pending_cmds[$];
   step_rsp_type expected_rsps[$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        mismatch_count = 0;
   int        cycle_count = 0;
   int        queued_count = 0;
   logic      req_fire = 1'b0;

   // Mirror of the block's registers and move state.
   logic        stealth_cfg = 1'b0;
   logic [13:0] min_speed_cfg = 14'd200;
   logic [63:0] speed_q = '0;
   logic [15:0] steps_left = '0;
   logic [15:0] steps_done = '0;
   logic [15:0] ramp_steps = '0;
   ramp_phase_type ramp_phase = RAMP_UP;
   logic        mv_active = 1'b0;
   logic [1:0]  mv_axis = '0;
   logic        mv_forward = 1'b0;
   logic        mv_stall_on = 1'b0;
   logic        mv_sensor_on = 1'b0;
   logic        mv_dir = 1'b0;
   logic [13:0] mv_top = '0;
   logic [15:0] mv_acc = '0;

   stepper_trapezoid_ramp dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] min_speed_q();
      return 64'(min_speed_cfg == 0 ? 14'd1 : min_speed_cfg) << FRAC_BITS;
   endfunction

   function automatic void ramp_predict(step_cmd_type c);
      step_rsp_type r;
      logic [15:0] mag;
      logic [63:0] v, d, w, top_q, lo, num;
      r.pulse = 1'b0;
      r.wait_us = '0;
      r.status = ST_DONE;
      if (c.op == OP_START) begin
         mag = c.steps[15] ? -c.steps : c.steps;
         mv_active = 1'b0;
         mv_axis = '0;
         mv_forward = 1'b0;
         mv_stall_on = 1'b0;
         mv_sensor_on = 1'b0;
         mv_dir = 1'b0;
         mv_top = '0;
         mv_acc = '0;
         steps_left = '0;
         steps_done = '0;
         ramp_steps = '0;
         ramp_phase = RAMP_UP;
         speed_q = min_speed_q();
         if (c.axis <= AXIS_IDLER) begin
            mv_axis = c.axis;
            mv_forward = !c.steps[15] && c.steps != 0;
            mv_dir = (c.axis == AXIS_PULLEY) ? c.steps[15] : !c.steps[15];
            mv_stall_on = c.stall_en && !stealth_cfg;
            mv_sensor_on = c.sensor_en;
            mv_top = (c.top == 0) ? 14'd1 : c.top;
            mv_acc = c.acc;
            steps_left = mag;
            mv_active = steps_left != 0;
         end
         r.status = mv_active ? ST_RUN : ST_DONE;
      end else if (mv_active) begin
         r.pulse = 1'b1;
         if (mv_stall_on && c.stall_seen) begin
            mv_active = 1'b0;
            r.status = ST_STALL;
         end else if (mv_axis == AXIS_PULLEY && mv_sensor_on &&
                      (mv_forward ? c.fil_seen : !c.fil_seen)) begin
            mv_active = 1'b0;
            r.status = ST_DONE;
         end else begin
            top_q = 64'(mv_top) << FRAC_BITS;
            v = speed_q;
            steps_done = steps_done + 16'd1;
            steps_left = steps_left - 16'd1;
            w = (64'd1000000 << FRAC_BITS) / v;
            if (w > 64'(WAIT_MAX)) w = 64'(WAIT_MAX);
            num = 64'(mv_acc) << FRAC_BITS;
            d = ((num / v) << FRAC_BITS) + (((num % v) << FRAC_BITS) / v);
            if (ramp_phase == RAMP_UP) begin
               v = v + d;
               if (v >= top_q) begin
                  ramp_steps = steps_done;
                  ramp_phase = RAMP_CRUISE;
                  v = top_q;
               end else if (steps_done > steps_left) begin
                  ramp_steps = steps_done;
                  ramp_phase = RAMP_DOWN;
               end
            end else if (ramp_phase == RAMP_CRUISE) begin
               if (steps_left <= ramp_steps) ramp_phase = RAMP_DOWN;
            end else begin
               lo = min_speed_q();
               v = (d >= v) ? lo : v - d;
               if (v < lo) v = lo;
            end
            speed_q = v;
            if (steps_left == 0) begin
               mv_active = 1'b0;
               r.status = ST_DONE;
            end else begin
               r.status = ST_RUN;
               r.wait_us = w[WAIT_W-1:0];
            end
         end
      end
      r.dir = mv_dir;
      expected_rsps.push_back(r);
   endfunction

   function automatic step_cmd_type mk(logic op, logic [1:0] axis, int steps, int top, int acc,
                                       logic se, logic sse, logic ss, logic fs);
      step_cmd_type c;
      c.op = op;
      c.axis = axis;
      c.steps = 16'(steps);
      c.top = 14'(top);
      c.acc = 16'(acc);
      c.stall_en = se;
      c.sensor_en = sse;
      c.stall_seen = ss;
      c.fil_seen = fs;
      return c;
   endfunction

   function automatic void queue_cmd(step_cmd_type c);
      pending_cmds.push_back(c);
      queued_count++;
   endfunction

   // One start followed by its steps with random sensor samples; sometimes cut short.
   function automatic void queue_move();
      step_cmd_type s, c;
      int        mag, n;
      logic      backward;
      s = mk(OP_START, 2'($urandom_range(2)), 0, $urandom_range(16383), $urandom,
             1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
      if ($urandom_range(19) == 0) s.axis = 2'd3;
      if ($urandom_range(9) == 0) begin
         s.steps = 16'($urandom);
         mag = 6;
      end else begin
         mag = $urandom_range(40);
         s.steps = $urandom_range(1) ? 16'(-mag) : 16'(mag);
      end
      if ($urandom_range(3) == 0) s.top = 14'($urandom_range(3000));
      queue_cmd(s);
      backward = s.steps[15];
      n = mag + $urandom_range(2);
      if ($urandom_range(7) == 0) n = $urandom_range(n);
      for (int i = 0; i < n; i++) begin
         c = mk(OP_STEP, 2'($urandom), $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                1'($urandom_range(1)), $urandom_range(24) == 0, 1'b0);
         c.fil_seen = backward ? ($urandom_range(19) != 0) : ($urandom_range(19) == 0);
         queue_cmd(c);
      end
   endfunction

   task automatic csr_write(logic idx, logic [13:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_STEALTH) stealth_cfg = val[0];
      else min_speed_cfg = val;
   endtask

   task automatic drain();
      wait (pending_cmds.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      queued_count = 0;
      while (queued_count < count) queue_move();
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      csr_write(CSR_STEALTH, 14'd0);
      csr_write(CSR_MIN_SPEED, 14'd200);
      send_idle_pct = 33;
      recv_idle_pct = 85;
      queue_cmd(mk(OP_START, AXIS_PULLEY, 3, 16383, 65535, 0, 0, 0, 0));
      repeat (4) queue_cmd(mk(OP_STEP, AXIS_PULLEY, 0, 0, 0, 0, 0, 0, 0));
      queue_cmd(mk(OP_START, 2'd3, 5, 100, 100, 0, 0, 0, 0));
      queue_cmd(mk(OP_STEP, 2'd3, 0, 0, 0, 0, 0, 0, 0));
      queue_cmd(mk(OP_START, 2'd1, 0, 100, 100, 0, 0, 0, 0));
      queue_cmd(mk(OP_START, 2'd1, -32768, 0, 0, 1, 1, 0, 1));
      repeat (2) queue_cmd(mk(OP_STEP, 2'd1, -1, 16383, 65535, 1, 1, 0, 1));
      queue_cmd(mk(OP_START, AXIS_IDLER, 32767, 16383, 65535, 1, 0, 0, 0));
      queue_cmd(mk(OP_STEP, AXIS_IDLER, 0, 0, 0, 0, 0, 0, 0));
      queue_cmd(mk(OP_STEP, AXIS_IDLER, 0, 0, 0, 0, 0, 1, 0));
      queue_cmd(mk(OP_START, AXIS_PULLEY, 8, 400, 1000, 0, 1, 0, 0));
      queue_cmd(mk(OP_STEP, AXIS_PULLEY, 0, 0, 0, 0, 0, 0, 0));
      queue_cmd(mk(OP_STEP, AXIS_PULLEY, 0, 0, 0, 0, 0, 0, 1));
      queue_cmd(mk(OP_START, AXIS_PULLEY, -5, 400, 1000, 0, 1, 0, 1));
      queue_cmd(mk(OP_STEP, AXIS_PULLEY, 0, 0, 0, 0, 0, 0, 1));
      queue_cmd(mk(OP_STEP, AXIS_PULLEY, 0, 0, 0, 0, 0, 0, 0));
      drain();
      run_random(130, 33, 85);
      csr_write(CSR_STEALTH, 14'd1);
      csr_write(CSR_MIN_SPEED, 14'd16383);
      run_random(130, 85, 33);
      csr_write(CSR_STEALTH, 14'd0);
      csr_write(CSR_MIN_SPEED, 14'd0);
      run_random(70, 0, 0);
      csr_write(CSR_MIN_SPEED, 14'($urandom_range(1, 2000)));
      run_random(70, 0, 0);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_valid && !req_fire) begin
            req_valid <= 1'b1;
         end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_op <= pending_cmds[0].op;
            req_axis <= pending_cmds[0].axis;
            req_move_steps <= pending_cmds[0].steps;
            req_top_speed <= pending_cmds[0].top;
            req_accel <= pending_cmds[0].acc;
            req_stall_enable <= pending_cmds[0].stall_en;
            req_sensor_stop_enable <= pending_cmds[0].sensor_en;
            req_stall_seen <= pending_cmds[0].stall_seen;
            req_filament_seen <= pending_cmds[0].fil_seen;
            void'(pending_cmds.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      step_rsp_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            ramp_predict(mk(req_op, req_axis, req_move_steps, req_top_speed, req_accel,
                            req_stall_enable, req_sensor_stop_enable, req_stall_seen,
                            req_filament_seen));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected transfer on the result channel.");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_pulse !== e.pulse || rsp_dir_level !== e.dir ||
                   rsp_wait_us !== e.wait_us || rsp_status !== e.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              e.pulse, e.dir, e.wait_us, e.status,
                              rsp_pulse, rsp_dir_level, rsp_wait_us, rsp_status);
               end
            end
         end
      end
   end

endmodule

// File: sim.f
rtl/stpr_pkg.sv
rtl/stpr_div.sv
rtl/stpr_datapath.sv
rtl/stpr_ctrl.sv
rtl/stepper_trapezoid_ramp.sv
tb/stepper_trapezoid_ramp_tb.sv
